### rtl/unicode_to_cp437_encoder_unit_assert.svh
// Assertion macros shared by the encoder RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef UNICODE_TO_CP437_ENCODER_UNIT_ASSERT_SVH
`define UNICODE_TO_CP437_ENCODER_UNIT_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define U2C_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same, checked during reset as well.
`define U2C_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/u2c_pkg.sv
// Types and the constant range table of the code page 437 encoder.
// No dependencies.
`timescale 1ns / 1ps

package u2c_pkg;

  localparam int RangeCount = 169;
  localparam int IdxW       = $clog2(RangeCount);
  localparam int CpW        = 16;
  localparam logic [7:0] MissGlyph = 8'h3F;

  typedef struct packed {
    logic [15:0] first;
    logic [7:0]  glyph;
    logic [7:0]  extra;
  } range_t;

  // Stage 1 to match unit
  typedef struct packed {
    logic           valid;
    logic           in_range;
    logic [CpW-1:0] cp;
  } cp_stage_t;

  // Match unit to output stage
  typedef struct packed {
    logic            valid;
    logic            hit;
    logic [IdxW-1:0] idx;
    logic [CpW-1:0]  cp;
  } sel_stage_t;

  // Sorted, non-overlapping ranges: first, base byte, extra run length
  localparam range_t RangeTable [RangeCount] = '{
    '{16'h0020, 8'h20, 8'h5e}, '{16'h00a0, 8'h20, 8'h00}, '{16'h00a1, 8'had, 8'h00},
    '{16'h00a2, 8'h9b, 8'h00}, '{16'h00a3, 8'h9c, 8'h00}, '{16'h00a5, 8'h9d, 8'h00},
    '{16'h00a7, 8'h15, 8'h00}, '{16'h00aa, 8'ha6, 8'h00}, '{16'h00ab, 8'hae, 8'h00},
    '{16'h00ac, 8'haa, 8'h00}, '{16'h00b0, 8'hf8, 8'h00}, '{16'h00b1, 8'hf1, 8'h00},
    '{16'h00b2, 8'hfd, 8'h00}, '{16'h00b5, 8'he6, 8'h00}, '{16'h00b6, 8'h14, 8'h00},
    '{16'h00b7, 8'hfa, 8'h00}, '{16'h00ba, 8'ha7, 8'h00}, '{16'h00bb, 8'haf, 8'h00},
    '{16'h00bc, 8'hac, 8'h00}, '{16'h00bd, 8'hab, 8'h00}, '{16'h00bf, 8'ha8, 8'h00},
    '{16'h00c4, 8'h8e, 8'h01}, '{16'h00c6, 8'h92, 8'h00}, '{16'h00c7, 8'h80, 8'h00},
    '{16'h00c9, 8'h90, 8'h00}, '{16'h00d1, 8'ha5, 8'h00}, '{16'h00d6, 8'h99, 8'h00},
    '{16'h00dc, 8'h9a, 8'h00}, '{16'h00df, 8'he1, 8'h00}, '{16'h00e0, 8'h85, 8'h00},
    '{16'h00e1, 8'ha0, 8'h00}, '{16'h00e2, 8'h83, 8'h00}, '{16'h00e4, 8'h84, 8'h00},
    '{16'h00e5, 8'h86, 8'h00}, '{16'h00e6, 8'h91, 8'h00}, '{16'h00e7, 8'h87, 8'h00},
    '{16'h00e8, 8'h8a, 8'h00}, '{16'h00e9, 8'h82, 8'h00}, '{16'h00ea, 8'h88, 8'h01},
    '{16'h00ec, 8'h8d, 8'h00}, '{16'h00ed, 8'ha1, 8'h00}, '{16'h00ee, 8'h8c, 8'h00},
    '{16'h00ef, 8'h8b, 8'h00}, '{16'h00f0, 8'heb, 8'h00}, '{16'h00f1, 8'ha4, 8'h00},
    '{16'h00f2, 8'h95, 8'h00}, '{16'h00f3, 8'ha2, 8'h00}, '{16'h00f4, 8'h93, 8'h00},
    '{16'h00f6, 8'h94, 8'h00}, '{16'h00f7, 8'hf6, 8'h00}, '{16'h00f8, 8'hed, 8'h00},
    '{16'h00f9, 8'h97, 8'h00}, '{16'h00fa, 8'ha3, 8'h00}, '{16'h00fb, 8'h96, 8'h00},
    '{16'h00fc, 8'h81, 8'h00}, '{16'h00ff, 8'h98, 8'h00}, '{16'h0192, 8'h9f, 8'h00},
    '{16'h0393, 8'he2, 8'h00}, '{16'h0398, 8'he9, 8'h00}, '{16'h03a3, 8'he4, 8'h00},
    '{16'h03a6, 8'he8, 8'h00}, '{16'h03a9, 8'hea, 8'h00}, '{16'h03b1, 8'he0, 8'h01},
    '{16'h03b4, 8'heb, 8'h00}, '{16'h03b5, 8'hee, 8'h00}, '{16'h03bc, 8'he6, 8'h00},
    '{16'h03c0, 8'he3, 8'h00}, '{16'h03c3, 8'he5, 8'h00}, '{16'h03c4, 8'he7, 8'h00},
    '{16'h03c6, 8'hed, 8'h00}, '{16'h03d5, 8'hed, 8'h00}, '{16'h2010, 8'h2d, 8'h00},
    '{16'h2014, 8'h2d, 8'h00}, '{16'h2018, 8'h60, 8'h00}, '{16'h2019, 8'h27, 8'h00},
    '{16'h201c, 8'h22, 8'h00}, '{16'h201d, 8'h22, 8'h00}, '{16'h2022, 8'h07, 8'h00},
    '{16'h203c, 8'h13, 8'h00}, '{16'h207f, 8'hfc, 8'h00}, '{16'h20a7, 8'h9e, 8'h00},
    '{16'h20ac, 8'hee, 8'h00}, '{16'h2126, 8'hea, 8'h00}, '{16'h2190, 8'h1b, 8'h00},
    '{16'h2191, 8'h18, 8'h00}, '{16'h2192, 8'h1a, 8'h00}, '{16'h2193, 8'h19, 8'h00},
    '{16'h2194, 8'h1d, 8'h00}, '{16'h2195, 8'h12, 8'h00}, '{16'h21a8, 8'h17, 8'h00},
    '{16'h2202, 8'heb, 8'h00}, '{16'h2208, 8'hee, 8'h00}, '{16'h2211, 8'he4, 8'h00},
    '{16'h2212, 8'h2d, 8'h00}, '{16'h2219, 8'hf9, 8'h00}, '{16'h221a, 8'hfb, 8'h00},
    '{16'h221e, 8'hec, 8'h00}, '{16'h221f, 8'h1c, 8'h00}, '{16'h2229, 8'hef, 8'h00},
    '{16'h2248, 8'hf7, 8'h00}, '{16'h2261, 8'hf0, 8'h00}, '{16'h2264, 8'hf3, 8'h00},
    '{16'h2265, 8'hf2, 8'h00}, '{16'h2302, 8'h7f, 8'h00}, '{16'h2310, 8'ha9, 8'h00},
    '{16'h2320, 8'hf4, 8'h00}, '{16'h2321, 8'hf5, 8'h00}, '{16'h2500, 8'hc4, 8'h00},
    '{16'h2502, 8'hb3, 8'h00}, '{16'h250c, 8'hda, 8'h00}, '{16'h2510, 8'hbf, 8'h00},
    '{16'h2514, 8'hc0, 8'h00}, '{16'h2518, 8'hd9, 8'h00}, '{16'h251c, 8'hc3, 8'h00},
    '{16'h2524, 8'hb4, 8'h00}, '{16'h252c, 8'hc2, 8'h00}, '{16'h2534, 8'hc1, 8'h00},
    '{16'h253c, 8'hc5, 8'h00}, '{16'h2550, 8'hcd, 8'h00}, '{16'h2551, 8'hba, 8'h00},
    '{16'h2552, 8'hd5, 8'h00}, '{16'h2553, 8'hd6, 8'h00}, '{16'h2554, 8'hc9, 8'h00},
    '{16'h2555, 8'hb8, 8'h00}, '{16'h2556, 8'hb7, 8'h00}, '{16'h2557, 8'hbb, 8'h00},
    '{16'h2558, 8'hd4, 8'h00}, '{16'h2559, 8'hd3, 8'h00}, '{16'h255a, 8'hc8, 8'h00},
    '{16'h255b, 8'hbe, 8'h00}, '{16'h255c, 8'hbd, 8'h00}, '{16'h255d, 8'hbc, 8'h00},
    '{16'h255e, 8'hc6, 8'h01}, '{16'h2560, 8'hcc, 8'h00}, '{16'h2561, 8'hb5, 8'h00},
    '{16'h2562, 8'hb6, 8'h00}, '{16'h2563, 8'hb9, 8'h00}, '{16'h2564, 8'hd1, 8'h01},
    '{16'h2566, 8'hcb, 8'h00}, '{16'h2567, 8'hcf, 8'h00}, '{16'h2568, 8'hd0, 8'h00},
    '{16'h2569, 8'hca, 8'h00}, '{16'h256a, 8'hd8, 8'h00}, '{16'h256b, 8'hd7, 8'h00},
    '{16'h256c, 8'hce, 8'h00}, '{16'h2580, 8'hdf, 8'h00}, '{16'h2584, 8'hdc, 8'h00},
    '{16'h2588, 8'hdb, 8'h00}, '{16'h258c, 8'hdd, 8'h00}, '{16'h2590, 8'hde, 8'h00},
    '{16'h2591, 8'hb0, 8'h02}, '{16'h25a0, 8'hfe, 8'h00}, '{16'h25ac, 8'h16, 8'h00},
    '{16'h25b2, 8'h1e, 8'h00}, '{16'h25ba, 8'h10, 8'h00}, '{16'h25bc, 8'h1f, 8'h00},
    '{16'h25c4, 8'h11, 8'h00}, '{16'h25cb, 8'h09, 8'h00}, '{16'h25d8, 8'h08, 8'h00},
    '{16'h25d9, 8'h0a, 8'h00}, '{16'h263a, 8'h01, 8'h01}, '{16'h263c, 8'h0f, 8'h00},
    '{16'h2640, 8'h0c, 8'h00}, '{16'h2642, 8'h0b, 8'h00}, '{16'h2660, 8'h06, 8'h00},
    '{16'h2663, 8'h05, 8'h00}, '{16'h2665, 8'h03, 8'h01}, '{16'h266a, 8'h0d, 8'h00},
    '{16'h266c, 8'h0e, 8'h00}
  };

  // Bounded table read; indexes past the last entry return an empty range
  function automatic range_t range_at(input logic [IdxW-1:0] idx);
    range_t r;
    r = '0;
    if (int'(idx) < RangeCount) begin
      r = RangeTable[idx];
    end
    return r;
  endfunction

endpackage

### rtl/u2c_match.sv
// Range match unit: parallel compare stage, then index encode stage.
// Depends on u2c_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "unicode_to_cp437_encoder_unit_assert.svh"

module u2c_match (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  u2c_pkg::cp_stage_t  cp_i,
  output u2c_pkg::sel_stage_t sel_o
);
  import u2c_pkg::*;

  logic [RangeCount-1:0] match_d, match_q;
  logic                  valid2_q;
  logic [CpW-1:0]        cp2_q;
  sel_stage_t            sel_d, sel_q;

  // Stage 2: one compare pair per table entry
  always_comb begin
    logic [CpW:0] hi;
    for (int i = 0; i < RangeCount; i++) begin
      hi = {1'b0, RangeTable[i].first} + {{(CpW-7){1'b0}}, RangeTable[i].extra};
      match_d[i] = cp_i.in_range && (cp_i.cp >= RangeTable[i].first) &&
                   ({1'b0, cp_i.cp} <= hi);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
    end else begin
      valid2_q <= cp_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    match_q <= match_d;
    cp2_q   <= cp_i.cp;
  end

  // Stage 3: ranges never overlap, so an OR of indexes encodes the hit
  always_comb begin
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int i = 0; i < RangeCount; i++) begin
      idx = idx | ({IdxW{match_q[i]}} & IdxW'(i));
    end
    sel_d.valid = valid2_q;
    sel_d.hit   = |match_q;
    sel_d.idx   = idx;
    sel_d.cp    = cp2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
    end else begin
      sel_q <= sel_d;
    end
  end

  assign sel_o = sel_q;

  `U2C_ASSERT(a_match_onehot0, $onehot0(match_q), "more than one range matched")
  `U2C_ASSERT(a_hit_follows_match, sel_q.valid |-> (sel_q.hit == $past(|match_q)),
              "hit flag lost between match and encode")
  `U2C_ASSERT(a_hit_index_in_table, sel_q.valid && sel_q.hit |-> int'(sel_q.idx) < RangeCount,
              "encoded index past the table")

endmodule

### rtl/unicode_to_cp437_encoder_unit.sv
// Top level: Unicode code point to code page 437 byte, four register stages.
// Depends on u2c_pkg, u2c_match and the assertion macro header.
//
//   port group    dir  handshake       payload
//   command       in   start_i/busy_o  code_point_i[31:0]
//   result        out  done_o          glyph_byte_o[7:0], mapped_o
//
// One code point enters per cycle; busy_o is never raised.
// The stages in order: input register, range compare, index encode,
// table read plus offset add. done_o is high in each cycle that carries a result.
// Reset clears the valid bits and the stage 1 and stage 3 registers; the
// result side cannot stall.
`timescale 1ns / 1ps
`include "unicode_to_cp437_encoder_unit_assert.svh"

module unicode_to_cp437_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] code_point_i,
  output logic        done_o,
  output logic [7:0]  glyph_byte_o,
  output logic        mapped_o
);
  import u2c_pkg::*;

  cp_stage_t  cp_q;
  sel_stage_t sel;
  range_t     entry;
  logic [7:0] glyph_d, glyph_q;
  logic       mapped_q, done_q;

  assign busy_o = 1'b0;

  // Stage 1: anything above 16 bits is outside every range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q <= '0;
    end else begin
      cp_q.valid    <= start_i && !busy_o;
      cp_q.in_range <= (code_point_i[31:CpW] == '0);
      cp_q.cp       <= code_point_i[CpW-1:0];
    end
  end

  u2c_match u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cp_i   (cp_q),
    .sel_o  (sel)
  );

  // Stage 4: runs are at most 95 codes long, so low bytes give the offset
  always_comb begin
    entry   = range_at(sel.idx);
    glyph_d = sel.hit ? entry.glyph + (sel.cp[7:0] - entry.first[7:0]) : MissGlyph;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sel.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    glyph_q  <= glyph_d;
    mapped_q <= sel.hit;
  end

  assign done_o       = done_q;
  assign glyph_byte_o = glyph_q;
  assign mapped_o     = mapped_q;

  `U2C_ASSERT(a_fixed_latency, start_i && !busy_o |-> ##4 done_o,
              "result strobe missing four cycles after a transaction")
  `U2C_ASSERT(a_no_spurious_done, done_o |-> $past(start_i, 4),
              "result strobe without a transaction")
  `U2C_ASSERT(a_miss_glyph, done_o && !mapped_o |-> glyph_byte_o == MissGlyph,
              "miss did not return the default glyph")
  `U2C_ASSERT_ALWAYS(a_busy_low, !busy_o, "busy raised on a fully pipelined unit")

endmodule

### bench/tb_top.sv
// Testbench for unicode_to_cp437_encoder_unit: one code point in, one CP437 byte out.
// Holds its own range table and lookup. Every result is checked against it in order.
// Depends only on the RTL of the encoder.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [7:0] glyph;
    logic       mapped;
  } glyph_result_t;

  localparam int NumRanges = 169;
  localparam logic [7:0] NoGlyph = 8'h3F;

  // {first code point, base byte, extra run length}
  logic [31:0] glyph_ranges [NumRanges] = '{
    32'h0020_205e, 32'h00a0_2000, 32'h00a1_ad00, 32'h00a2_9b00, 32'h00a3_9c00, 32'h00a5_9d00,
    32'h00a7_1500, 32'h00aa_a600, 32'h00ab_ae00, 32'h00ac_aa00, 32'h00b0_f800, 32'h00b1_f100,
    32'h00b2_fd00, 32'h00b5_e600, 32'h00b6_1400, 32'h00b7_fa00, 32'h00ba_a700, 32'h00bb_af00,
    32'h00bc_ac00, 32'h00bd_ab00, 32'h00bf_a800, 32'h00c4_8e01, 32'h00c6_9200, 32'h00c7_8000,
    32'h00c9_9000, 32'h00d1_a500, 32'h00d6_9900, 32'h00dc_9a00, 32'h00df_e100, 32'h00e0_8500,
    32'h00e1_a000, 32'h00e2_8300, 32'h00e4_8400, 32'h00e5_8600, 32'h00e6_9100, 32'h00e7_8700,
    32'h00e8_8a00, 32'h00e9_8200, 32'h00ea_8801, 32'h00ec_8d00, 32'h00ed_a100, 32'h00ee_8c00,
    32'h00ef_8b00, 32'h00f0_eb00, 32'h00f1_a400, 32'h00f2_9500, 32'h00f3_a200, 32'h00f4_9300,
    32'h00f6_9400, 32'h00f7_f600, 32'h00f8_ed00, 32'h00f9_9700, 32'h00fa_a300, 32'h00fb_9600,
    32'h00fc_8100, 32'h00ff_9800, 32'h0192_9f00, 32'h0393_e200, 32'h0398_e900, 32'h03a3_e400,
    32'h03a6_e800, 32'h03a9_ea00, 32'h03b1_e001, 32'h03b4_eb00, 32'h03b5_ee00, 32'h03bc_e600,
    32'h03c0_e300, 32'h03c3_e500, 32'h03c4_e700, 32'h03c6_ed00, 32'h03d5_ed00, 32'h2010_2d00,
    32'h2014_2d00, 32'h2018_6000, 32'h2019_2700, 32'h201c_2200, 32'h201d_2200, 32'h2022_0700,
    32'h203c_1300, 32'h207f_fc00, 32'h20a7_9e00, 32'h20ac_ee00, 32'h2126_ea00, 32'h2190_1b00,
    32'h2191_1800, 32'h2192_1a00, 32'h2193_1900, 32'h2194_1d00, 32'h2195_1200, 32'h21a8_1700,
    32'h2202_eb00, 32'h2208_ee00, 32'h2211_e400, 32'h2212_2d00, 32'h2219_f900, 32'h221a_fb00,
    32'h221e_ec00, 32'h221f_1c00, 32'h2229_ef00, 32'h2248_f700, 32'h2261_f000, 32'h2264_f300,
    32'h2265_f200, 32'h2302_7f00, 32'h2310_a900, 32'h2320_f400, 32'h2321_f500, 32'h2500_c400,
    32'h2502_b300, 32'h250c_da00, 32'h2510_bf00, 32'h2514_c000, 32'h2518_d900, 32'h251c_c300,
    32'h2524_b400, 32'h252c_c200, 32'h2534_c100, 32'h253c_c500, 32'h2550_cd00, 32'h2551_ba00,
    32'h2552_d500, 32'h2553_d600, 32'h2554_c900, 32'h2555_b800, 32'h2556_b700, 32'h2557_bb00,
    32'h2558_d400, 32'h2559_d300, 32'h255a_c800, 32'h255b_be00, 32'h255c_bd00, 32'h255d_bc00,
    32'h255e_c601, 32'h2560_cc00, 32'h2561_b500, 32'h2562_b600, 32'h2563_b900, 32'h2564_d101,
    32'h2566_cb00, 32'h2567_cf00, 32'h2568_d000, 32'h2569_ca00, 32'h256a_d800, 32'h256b_d700,
    32'h256c_ce00, 32'h2580_df00, 32'h2584_dc00, 32'h2588_db00, 32'h258c_dd00, 32'h2590_de00,
    32'h2591_b002, 32'h25a0_fe00, 32'h25ac_1600, 32'h25b2_1e00, 32'h25ba_1000, 32'h25bc_1f00,
    32'h25c4_1100, 32'h25cb_0900, 32'h25d8_0800, 32'h25d9_0a00, 32'h263a_0101, 32'h263c_0f00,
    32'h2640_0c00, 32'h2642_0b00, 32'h2660_0600, 32'h2663_0500, 32'h2665_0301, 32'h266a_0d00,
    32'h266c_0e00
  };

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [31:0] code_point_i;
  logic        done_o;
  logic [7:0]  glyph_byte_o;
  logic        mapped_o;

  glyph_result_t glyph_due[$];
  int unsigned   mismatch_count;

  unicode_to_cp437_encoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .code_point_i(code_point_i),
    .done_o      (done_o),
    .glyph_byte_o(glyph_byte_o),
    .mapped_o    (mapped_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Range match over the whole 32-bit code point; a miss gives '?'
  function automatic glyph_result_t cp437_lookup(input logic [31:0] cp);
    glyph_result_t r;
    logic [31:0]   lo;
    logic [31:0]   hi;
    r.glyph  = NoGlyph;
    r.mapped = 1'b0;
    for (int i = 0; i < NumRanges; i++) begin
      lo = {16'h0, glyph_ranges[i][31:16]};
      hi = lo + {24'h0, glyph_ranges[i][7:0]};
      if (cp >= lo && cp <= hi) begin
        r.glyph  = glyph_ranges[i][15:8] + 8'(cp - lo);
        r.mapped = 1'b1;
      end
    end
    return r;
  endfunction

  // Half near table runs, with run edges; the rest in the low 16 bits, with upper bits set, or over all 32 bits
  function automatic logic [31:0] pick_code_point();
    int unsigned sel;
    int unsigned idx;
    int unsigned k;
    logic [31:0] first;
    sel   = $urandom_range(0, 99);
    idx   = $urandom_range(0, NumRanges - 1);
    first = {16'h0, glyph_ranges[idx][31:16]};
    if (sel < 50) begin
      k = $urandom_range(0, glyph_ranges[idx][7:0] + 2);
      return first + k - 1;
    end else if (sel < 65) begin
      return $urandom_range(0, 32'h2700);
    end else if (sel < 75) begin
      return $urandom_range(0, 32'hffff);
    end else if (sel < 85) begin
      // table hit pattern in the low half, upper half nonzero
      return {16'($urandom_range(1, 16'hffff)), first[15:0]};
    end else begin
      return $urandom;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // One transaction; start_i stays high for a following send
  task automatic send_code(input logic [31:0] cp);
    @(negedge clk_i);
    start_i      = 1'b1;
    code_point_i = cp;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    glyph_due.push_back(cp437_lookup(cp));
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start_i      = 1'b0;
      code_point_i = $urandom;
    end
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 5));
  endtask

  task automatic wait_results_drained();
    idle_cycles(1);
    while (glyph_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_edges();
    logic [31:0] edge_cps [$];
    edge_cps = '{32'h0000_0000, 32'h0000_001f, 32'h0000_0020, 32'h0000_003f,
                 32'h0000_007e, 32'h0000_007f, 32'h0000_00a0, 32'h0000_00c4,
                 32'h0000_00c5, 32'h0000_00c6, 32'h0000_2591, 32'h0000_2592,
                 32'h0000_2593, 32'h0000_2594, 32'h0000_266c, 32'h0000_266d,
                 32'h0000_ffff, 32'h0001_0000, 32'h0001_0041, 32'h8000_266c,
                 32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff};
    foreach (edge_cps[i]) begin
      send_code(edge_cps[i]);
      maybe_idle();
    end
    wait_results_drained();
  endtask

  task automatic test_random_mix(input int unsigned n);
    repeat (n) begin
      send_code(pick_code_point());
      maybe_idle();
    end
  endtask

  // Back-to-back transactions, no gaps
  task automatic test_streaming(input int unsigned n);
    repeat (n) send_code(pick_code_point());
  endtask

  always @(posedge clk_i) begin
    glyph_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (glyph_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: glyph %02h mapped %b",
                                  glyph_byte_o, mapped_o));
      end else begin
        want = glyph_due.pop_front();
        if (glyph_byte_o !== want.glyph)
          report_mismatch($sformatf("glyph_byte %02h, want %02h", glyph_byte_o, want.glyph));
        if (mapped_o !== want.mapped)
          report_mismatch($sformatf("mapped %b, want %b", mapped_o, want.mapped));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("unicode_to_cp437_encoder_unit: mismatch");
    $finish;
  end

  initial begin
    int unsigned waited;
    mismatch_count = 0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    code_point_i   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_edges();
    test_random_mix(900);
    test_streaming(200);

    idle_cycles(1);
    waited = 0;
    while (glyph_due.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (glyph_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", glyph_due.size()));

    if (mismatch_count == 0) begin
      $display("unicode_to_cp437_encoder_unit: match");
    end else begin
      $display("unicode_to_cp437_encoder_unit: mismatch");
    end
    $finish;
  end

endmodule
